// ===== sv/bhei_pkg.sv =====
// Shared types, constants and saturating helpers for the hit energy integrator.
`timescale 1ns / 1ps

package bhei_pkg;

  // Widths of the shared divider datapath
  localparam int DVD_BITS  = 56;  // dividend, shifted in from the top
  localparam int DEN_BITS  = 37;  // divisor and partial remainder
  localparam int QUO_BITS  = 40;  // quotient register
  localparam int ITER_BITS = 6;   // iteration counter

  // Iterations per division
  localparam logic [ITER_BITS-1:0] QUENCH_ITERS = 6'd20;
  localparam logic [ITER_BITS-1:0] MEAN_ITERS   = 6'd40;

  // Mean clamp limits and the no-axis marker (4004 mm in 1/16 mm)
  localparam logic [QUO_BITS-1:0]  POS_MAX_MAG = 40'd524287;
  localparam logic [QUO_BITS-1:0]  NEG_MAX_MAG = 40'd524288;
  localparam logic signed [19:0]   POS_MAX     = 20'sh7FFFF;
  localparam logic signed [19:0]   POS_MIN     = 20'sh80000;
  localparam logic signed [19:0]   NO_AXIS_POS = 20'sd64064;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BIRKS  = 2'd0,
    CFG_HALF_X = 2'd1,
    CFG_HALF_Y = 2'd2,
    CFG_HALF_Z = 2'd3
  } cfg_idx_t;

  // One simulated step
  typedef struct packed {
    logic        [19:0] step_energy;
    logic        [19:0] step_length;
    logic signed [3:0]  step_charge;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic        [31:0] step_time;
    logic        [7:0]  sector_id;
    logic        [7:0]  layer_id;
    logic        [9:0]  channel_id;
    logic        [15:0] hit_number;
    logic               last_step;
  } bhei_in_t;

  // One finished hit
  typedef struct packed {
    logic        [15:0] out_hit_number;
    logic        [7:0]  out_sector;
    logic        [7:0]  out_layer;
    logic        [9:0]  out_channel;
    logic        [31:0] first_time;
    logic        [31:0] energy_total;
    logic        [31:0] energy_quenched;
    logic signed [19:0] hit_position;
    logic               axis_found;
  } bhei_out_t;

  // Divider request
  typedef struct packed {
    logic                 start;
    logic [ITER_BITS-1:0] iters;
    logic [DEN_BITS-1:0]  rem_init;
    logic [DVD_BITS-1:0]  dividend;
    logic [DEN_BITS-1:0]  divisor;
  } div_ctrl_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Unsigned add that clamps at 2^32-1
  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [19:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {13'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Signed add that clamps to the 40-bit range
  function automatic logic signed [39:0] sat_add40(input logic signed [39:0] a,
                                                    input logic signed [19:0] b);
    logic [40:0] s;
    s = {a[39], a} + {{21{b[19]}}, b};
    if (s[40] != s[39]) begin
      return s[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
    end
    return s[39:0];
  endfunction

endpackage

// ===== sv/bhei_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bhei_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bhei_pkg::div_ctrl_t           ctrl,
  output bhei_pkg::div_stat_t           stat,
  output logic [bhei_pkg::QUO_BITS-1:0] quotient
);
  import bhei_pkg::*;

  logic [DEN_BITS-1:0]  rem_r;
  logic [DVD_BITS-1:0]  dvd_r;
  logic [DEN_BITS-1:0]  den_r;
  logic [QUO_BITS-1:0]  quo_r;
  logic [ITER_BITS-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DEN_BITS:0]    trial;
  logic [DEN_BITS:0]    diff;
  logic                 fits;

  // Shift the next dividend bit into the remainder and try the subtract
  assign trial = {rem_r, dvd_r[DVD_BITS-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctrl.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ITER_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load on start, then one bit per cycle
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem_r <= ctrl.rem_init;
      dvd_r <= ctrl.dividend;
      den_r <= ctrl.divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      dvd_r <= {dvd_r[DVD_BITS-2:0], 1'b0};
      quo_r <= {quo_r[QUO_BITS-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  // Remainder stays below the divisor while iterating
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < den_r)
    else $error("divider remainder not below divisor");

  // No new request while a division runs
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.start |-> !busy_r)
    else $error("divider started while busy");

  // Done follows the final iteration
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without finishing");

endmodule

// ===== sv/birks_hit_energy_integrator.sv =====
// Top level: step accumulation, Birks quenching and hit mean under one sequencer.
//
//   channel | ports                              | word
//   --------+------------------------------------+----------------------------
//   input   | in_valid, in_stall, in_data        | one simulated step
//   output  | out_valid, out_stall, out_data     | one finished hit
//   config  | cfg_we, cfg_index, cfg_data        | one 16-bit register write
//
// A step passes through S_MUL, S_QSTART and S_QACC, waiting in S_QWAIT on the
// shared 1-bit-per-cycle divider (20 iterations) unless quenching is skipped.
// A last step then forms the mean (40 divider iterations) if an axis is found.
// Reset is synchronous, active low, and clears sums, count and configuration.
// A finished hit sits in the output register while the next step is taken;
// a last step waits in its final state while that register is still stalled.
`timescale 1ns / 1ps

module birks_hit_energy_integrator #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bhei_pkg::bhei_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bhei_pkg::bhei_out_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import bhei_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL    = 8'b0000_0010,
    S_QSTART = 8'b0000_0100,
    S_QWAIT  = 8'b0000_1000,
    S_QACC   = 8'b0001_0000,
    S_MSTART = 8'b0010_0000,
    S_MWAIT  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;

  logic [15:0]             kb_r, half_x_r, half_y_r, half_z_r;
  bhei_in_t                item_r;
  logic [39:0]             prod_ed_r;
  logic [35:0]             prod_ke_r;
  logic [31:0]             raw_sum_r, q_sum_r, start_time_r;
  logic signed [39:0]      sum_x_r, sum_y_r, sum_z_r;
  logic [COUNT_BITS-1:0]   steps_seen_r;
  logic                    mean_neg_r;
  logic                    axis_found_r;
  logic                    out_valid_r;
  bhei_out_t               out_data_r;

  div_ctrl_t               div_ctrl;
  div_stat_t               div_stat;
  logic [QUO_BITS-1:0]     div_quo;

  logic                    accept;
  logic                    out_free;
  logic                    bypass;
  logic                    pick_x, pick_y, pick_z;
  logic signed [39:0]      sel_sum;
  logic [39:0]             sel_mag;
  logic [DEN_BITS-1:0]     quench_den;
  logic signed [19:0]      mean_pos;

  assign accept   = in_valid && !in_stall;
  assign in_stall = state_r != S_IDLE;
  assign out_free = !out_valid_r || !out_stall;

  // Quench is skipped when any factor is zero
  assign bypass = (kb_r == '0) || (item_r.step_energy == '0) ||
                  (item_r.step_length == '0) || (item_r.step_charge == '0);

  // Unique longest half size picks the axis
  assign pick_x = (half_x_r > half_y_r) && (half_x_r > half_z_r);
  assign pick_y = (half_y_r > half_x_r) && (half_y_r > half_z_r);
  assign pick_z = (half_z_r > half_x_r) && (half_z_r > half_y_r);

  always_comb begin
    sel_sum = sum_z_r;
    if (pick_x) begin
      sel_sum = sum_x_r;
    end else if (pick_y) begin
      sel_sum = sum_y_r;
    end
  end

  assign sel_mag    = sel_sum[39] ? 40'(-sel_sum) : 40'(sel_sum);
  assign quench_den = {1'b0, item_r.step_length, 16'b0} + {1'b0, prod_ke_r};

  // Divider request: quench in S_QSTART, mean in S_MSTART
  always_comb begin
    div_ctrl          = '0;
    div_ctrl.iters    = QUENCH_ITERS;
    div_ctrl.rem_init = {1'b0, prod_ed_r[39:4]};
    div_ctrl.dividend = {prod_ed_r[3:0], {(DVD_BITS-4){1'b0}}};
    div_ctrl.divisor  = quench_den;
    if (state_r == S_QSTART) begin
      div_ctrl.start = !bypass;
    end else if (state_r == S_MSTART) begin
      div_ctrl.start    = pick_x || pick_y || pick_z;
      div_ctrl.iters    = MEAN_ITERS;
      div_ctrl.rem_init = '0;
      div_ctrl.dividend = {sel_mag, {(DVD_BITS-40){1'b0}}};
      div_ctrl.divisor  = {{(DEN_BITS-COUNT_BITS){1'b0}}, steps_seen_r};
    end
  end

  bhei_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // Sign back onto the mean and clamp to 20 bits
  always_comb begin
    if (!mean_neg_r) begin
      mean_pos = (div_quo > POS_MAX_MAG) ? POS_MAX : div_quo[19:0];
    end else begin
      mean_pos = (div_quo > NEG_MAX_MAG) ? POS_MIN : 20'(~div_quo[19:0] + 20'd1);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_QSTART;
      S_QSTART: state_nxt = bypass ? S_QACC : S_QWAIT;
      S_QWAIT:  if (div_stat.done) state_nxt = S_QACC;
      S_QACC:   state_nxt = item_r.last_step ? S_MSTART : S_IDLE;
      S_MSTART: state_nxt = (pick_x || pick_y || pick_z) ? S_MWAIT : S_OUT;
      S_MWAIT:  if (div_stat.done) state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kb_r     <= '0;
      half_x_r <= '0;
      half_y_r <= '0;
      half_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BIRKS:  kb_r     <= cfg_data;
        CFG_HALF_X: half_x_r <= cfg_data;
        CFG_HALF_Y: half_y_r <= cfg_data;
        CFG_HALF_Z: half_z_r <= cfg_data;
        default:    kb_r     <= kb_r;
      endcase
    end
  end

  // Hold the step and form both products
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (state_r == S_MUL) begin
      prod_ed_r <= {20'b0, item_r.step_energy} * {20'b0, item_r.step_length};
      prod_ke_r <= {20'b0, kb_r} * {16'b0, item_r.step_energy};
    end
  end

  // Per-hit sums: raw, positions and count on accept, quench in S_QACC, cleared on emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_sum_r    <= '0;
      q_sum_r      <= '0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      sum_z_r      <= '0;
      steps_seen_r <= '0;
      start_time_r <= '0;
    end else if (accept) begin
      if (steps_seen_r == '0) begin
        start_time_r <= in_data.step_time;
      end
      raw_sum_r <= sat_add32(raw_sum_r, in_data.step_energy);
      sum_x_r   <= sat_add40(sum_x_r, in_data.pos_x);
      sum_y_r   <= sat_add40(sum_y_r, in_data.pos_y);
      sum_z_r   <= sat_add40(sum_z_r, in_data.pos_z);
      if (steps_seen_r != '1) begin
        steps_seen_r <= steps_seen_r + 1'b1;
      end
    end else if (state_r == S_QACC) begin
      q_sum_r <= sat_add32(q_sum_r, bypass ? item_r.step_energy : div_quo[19:0]);
    end else if (state_r == S_OUT && out_free) begin
      raw_sum_r    <= '0;
      q_sum_r      <= '0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      sum_z_r      <= '0;
      steps_seen_r <= '0;
    end
  end

  // Latch sign and axis outcome at the start of the mean
  always_ff @(posedge clk) begin
    if (state_r == S_MSTART) begin
      mean_neg_r   <= sel_sum[39];
      axis_found_r <= pick_x || pick_y || pick_z;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_data_r.out_hit_number  <= item_r.hit_number;
      out_data_r.out_sector      <= item_r.sector_id;
      out_data_r.out_layer       <= item_r.layer_id;
      out_data_r.out_channel     <= item_r.channel_id;
      out_data_r.first_time      <= start_time_r;
      out_data_r.energy_total    <= raw_sum_r;
      out_data_r.energy_quenched <= q_sum_r;
      out_data_r.hit_position    <= axis_found_r ? mean_pos : NO_AXIS_POS;
      out_data_r.axis_found      <= axis_found_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Divider only finishes while the sequencer waits on it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_QWAIT || state_r == S_MWAIT))
    else $error("divider done outside a wait state");

  // The mean never divides by zero
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MSTART |-> steps_seen_r != '0)
    else $error("mean started with zero steps");

  // Emitting a hit clears the per-hit state
  a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (steps_seen_r == '0 && raw_sum_r == '0))
    else $error("hit state not cleared after emit");

  // No axis means the marker position
  a_no_axis_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.axis_found) |-> out_data_r.hit_position == NO_AXIS_POS)
    else $error("no-axis hit without marker position");

endmodule

// ===== tb/birks_hit_energy_integrator_test.sv =====
// Self-checking testbench for the Birks hit energy integrator: directed, axis and random hits.
`timescale 1ns / 1ps

module birks_hit_energy_integrator_test;
  import bhei_pkg::*;

  localparam int COUNT_BITS     = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_OFF_LEN   = 400;
  localparam longint SUM40_MAX  = (64'sd1 <<< 39) - 64'sd1;
  localparam longint SUM40_MIN  = -(64'sd1 <<< 39);

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  bhei_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  bhei_out_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Hit accumulator mirror: configuration and per-hit sums
  logic [15:0]           birks_kb, half_x, half_y, half_z;
  logic [31:0]           raw_total, quench_total, hit_start_time;
  logic signed [39:0]    sum_px, sum_py, sum_pz;
  logic [COUNT_BITS-1:0] steps_in_hit;

  bhei_out_t pending_hits[$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  int        hold_request = 0;
  bit        sender_gaps = 1'b1;
  bit        receiver_gaps = 1'b1;

  birks_hit_energy_integrator #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Quenched energy E*65536*dx / (65536*dx + kB*E), exact in 64 bits
  function automatic logic [63:0] quenched_energy(input logic [19:0] e, input logic [19:0] dx,
                                                  input logic signed [3:0] chg);
    logic [63:0] num;
    logic [63:0] den;
    if (birks_kb == 16'd0 || e == 20'd0 || dx == 20'd0 || chg == 4'sd0) return 64'(e);
    num = (64'(e) * 64'(dx)) << 16;
    den = (64'(dx) << 16) + 64'(birks_kb) * 64'(e);
    return num / den;
  endfunction

  function automatic logic [31:0] clamp_add_u32(input logic [31:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = 65'(a) + 65'(b);
    return (s > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic signed [39:0] clamp_add_s40(input logic signed [39:0] a,
                                                       input logic signed [19:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > SUM40_MAX) s = SUM40_MAX;
    if (s < SUM40_MIN) s = SUM40_MIN;
    return s[39:0];
  endfunction

  // Mean truncated toward zero, then clamped to the 20-bit signed range
  function automatic logic signed [19:0] axis_mean(input logic signed [39:0] sum,
                                                   input logic [COUNT_BITS-1:0] n);
    longint mag;
    longint m;
    mag = (sum < 0) ? -longint'(sum) : longint'(sum);
    mag = mag / longint'(n);
    m = (sum < 0) ? -mag : mag;
    if (m > 64'sd524287) m = 64'sd524287;
    if (m < -64'sd524288) m = -64'sd524288;
    return m[19:0];
  endfunction

  function automatic void clear_hit_sums();
    raw_total = '0;
    quench_total = '0;
    sum_px = '0;
    sum_py = '0;
    sum_pz = '0;
    steps_in_hit = '0;
  endfunction

  // Advance the mirror by one accepted step; queue the finished hit on a last step
  task automatic take_step(input bhei_in_t s);
    bhei_out_t hit;
    if (steps_in_hit == '0) hit_start_time = s.step_time;
    raw_total = clamp_add_u32(raw_total, 64'(s.step_energy));
    quench_total = clamp_add_u32(quench_total,
                                 quenched_energy(s.step_energy, s.step_length, s.step_charge));
    sum_px = clamp_add_s40(sum_px, s.pos_x);
    sum_py = clamp_add_s40(sum_py, s.pos_y);
    sum_pz = clamp_add_s40(sum_pz, s.pos_z);
    if (steps_in_hit != '1) steps_in_hit = steps_in_hit + 1'b1;
    if (s.last_step) begin
      hit.out_hit_number  = s.hit_number;
      hit.out_sector      = s.sector_id;
      hit.out_layer       = s.layer_id;
      hit.out_channel     = s.channel_id;
      hit.first_time      = hit_start_time;
      hit.energy_total    = raw_total;
      hit.energy_quenched = quench_total;
      hit.axis_found      = 1'b1;
      if (half_x > half_y && half_x > half_z) begin
        hit.hit_position = axis_mean(sum_px, steps_in_hit);
      end else if (half_y > half_x && half_y > half_z) begin
        hit.hit_position = axis_mean(sum_py, steps_in_hit);
      end else if (half_z > half_x && half_z > half_y) begin
        hit.hit_position = axis_mean(sum_pz, steps_in_hit);
      end else begin
        hit.hit_position = NO_AXIS_POS;
        hit.axis_found   = 1'b0;
      end
      pending_hits.insert(pending_hits.size(), hit);
      clear_hit_sums();
    end
  endtask

  // Drive one step word and hold it until the block takes it
  task automatic send_step(input bhei_in_t s);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_step(s);
  endtask

  // Drop valid and wait until every finished hit has come back and the block is idle
  task automatic drain_hits();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_BIRKS:  birks_kb = value;
      CFG_HALF_X: half_x = value;
      CFG_HALF_Y: half_y = value;
      CFG_HALF_Z: half_z = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] kb, input logic [15:0] hx,
                            input logic [15:0] hy, input logic [15:0] hz);
    write_reg(CFG_BIRKS, kb);
    write_reg(CFG_HALF_X, hx);
    write_reg(CFG_HALF_Y, hy);
    write_reg(CFG_HALF_Z, hz);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Field values biased toward zero, the sign boundary and all ones
  function automatic logic [19:0] spread20();
    case ($urandom_range(0, 7))
      0: return 20'h00000;
      1: return 20'hFFFFF;
      2: return 20'h80000;
      3: return 20'h7FFFF;
      4: return 20'($urandom_range(0, 15));
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_kb();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bhei_in_t random_step(input logic last);
    bhei_in_t s;
    s.step_energy = spread20();
    s.step_length = spread20();
    s.step_charge = 4'($urandom_range(0, 15));
    s.pos_x       = spread20();
    s.pos_y       = spread20();
    s.pos_z       = spread20();
    s.step_time   = $urandom;
    s.sector_id   = 8'($urandom);
    s.layer_id    = 8'($urandom);
    s.channel_id  = 10'($urandom);
    s.hit_number  = 16'($urandom);
    s.last_step   = last;
    return s;
  endfunction

  function automatic bhei_in_t dir_step(input logic [19:0] e, input logic [19:0] dx,
                                        input logic [3:0] chg, input logic [19:0] x,
                                        input logic [19:0] y, input logic [19:0] z,
                                        input logic [31:0] t, input logic last);
    bhei_in_t s;
    s = random_step(last);
    s.step_energy = e;
    s.step_length = dx;
    s.step_charge = chg;
    s.pos_x       = x;
    s.pos_y       = y;
    s.pos_z       = z;
    s.step_time   = t;
    return s;
  endfunction

  task automatic send_hit(input int n);
    for (int k = 1; k <= n; k++) send_step(random_step(k == n));
  endtask

  // Field extremes, quench skips on zero energy, length or charge, truncation of a negative mean
  task automatic test_directed_extremes();
    bhei_in_t s;
    set_config(16'h8000, 16'd100, 16'd50, 16'd10);
    s = dir_step(20'hFFFFF, 20'hFFFFF, 4'sd7, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF,
                 32'hFFFF_FFFF, 1'b1);
    s.sector_id  = 8'hFF;
    s.layer_id   = 8'hFF;
    s.channel_id = 10'h3FF;
    s.hit_number = 16'hFFFF;
    send_step(s);
    s = dir_step(20'd0, 20'd1, 4'sh8, 20'h80000, 20'h80000, 20'h80000, 32'd0, 1'b1);
    s.sector_id  = '0;
    s.layer_id   = '0;
    s.channel_id = '0;
    s.hit_number = '0;
    send_step(s);
    send_step(dir_step(20'hFFFFF, 20'd0, 4'hF, 20'd5, 20'd6, 20'd7, 32'd9, 1'b1));
    send_step(dir_step(20'd5000, 20'd200, 4'd0, 20'd1, 20'd2, 20'd3, 32'd10, 1'b1));
    // Sum of x is -7 over four steps: the mean truncates to -1
    send_step(dir_step(20'd1000, 20'd10, 4'd1, -20'sd3, 20'd8, 20'd0, 32'd111, 1'b0));
    send_step(dir_step(20'd2000, 20'd1, 4'hE, -20'sd4, 20'd8, 20'd0, 32'd222, 1'b0));
    send_step(dir_step(20'd1, 20'd1, 4'd3, 20'd0, 20'd8, 20'd0, 32'd333, 1'b0));
    send_step(dir_step(20'd7, 20'hFFFFF, 4'd2, 20'd0, 20'd8, 20'd0, 32'd444, 1'b1));
    drain_hits();
    set_config(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    send_step(dir_step(20'd1, 20'd1, 4'd1, 20'd9, 20'd0, 20'd0, 32'd1, 1'b0));
    send_step(dir_step(20'hFFFFF, 20'd1, 4'sh8, 20'd10, 20'd0, 20'd0, 32'd2, 1'b1));
    drain_hits();
  endtask

  task automatic axis_case(input logic [15:0] hx, input logic [15:0] hy, input logic [15:0] hz);
    set_config(pick_kb(), hx, hy, hz);
    send_hit(2);
    drain_hits();
  endtask

  // Unique longest axis in y and in z, and ties that give the no-axis marker
  task automatic test_axis_selection();
    axis_case(16'd0, 16'd0, 16'd0);
    axis_case(16'd5, 16'd5, 16'd1);
    axis_case(16'd1, 16'd5, 16'd5);
    axis_case(16'd5, 16'd1, 16'd5);
    axis_case(16'd1, 16'd9, 16'd3);
    axis_case(16'd1, 16'd3, 16'd9);
    axis_case(16'd7, 16'd7, 16'd7);
    axis_case(16'hFFFF, 16'hFFFF, 16'hFFFE);
  endtask

  // Receiver holds off while the sender keeps offering, then the sender waits for all
  task automatic test_backpressure();
    set_config(16'h0100, 16'd300, 16'd20, 16'd20);
    sender_gaps  = 1'b0;
    hold_request = HOLD_OFF_LEN;
    repeat (30) send_hit($urandom_range(1, 2));
    drain_hits();
    sender_gaps = 1'b1;
  endtask

  // Phases of random hits under random settings; one phase per side without gaps
  task automatic test_random_hits();
    int sent;
    int n;
    for (int phase = 0; phase < 5; phase++) begin
      sender_gaps   = (phase != 2);
      receiver_gaps = (phase != 3);
      set_config(pick_kb(), pick_half(), pick_half(), pick_half());
      sent = 0;
      while (sent < 195) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
        send_hit(n);
        sent += n;
      end
      drain_hits();
    end
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  function automatic void compare_field(input string label, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
      mismatch_count++;
    end
  endfunction

  // Check each finished hit against the oldest prediction
  always @(posedge clk) begin
    bhei_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected hit word, expected none, actual hit number 0x%0h",
                 $time, out_data.out_hit_number);
        mismatch_count++;
      end else begin
        want = pending_hits.pop_front();
        compare_field("out_hit_number", want.out_hit_number, out_data.out_hit_number);
        compare_field("out_sector", want.out_sector, out_data.out_sector);
        compare_field("out_layer", want.out_layer, out_data.out_layer);
        compare_field("out_channel", want.out_channel, out_data.out_channel);
        compare_field("first_time", want.first_time, out_data.first_time);
        compare_field("energy_total", want.energy_total, out_data.energy_total);
        compare_field("energy_quenched", want.energy_quenched, out_data.energy_quenched);
        compare_field("hit_position", want.hit_position, out_data.hit_position);
        compare_field("axis_found", want.axis_found, out_data.axis_found);
      end
    end
  end

  // Count cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: stall a random number of cycles per word, or a long hold-off on request
  initial begin : result_taker
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = receiver_gaps ? $urandom_range(0, 15) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : run
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_BIRKS;
    cfg_data  = '0;
    birks_kb  = '0;
    half_x    = '0;
    half_y    = '0;
    half_z    = '0;
    hit_start_time = '0;
    clear_hit_sums();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_extremes();
    test_axis_selection();
    test_backpressure();
    test_random_hits();

    drain_hits();
    if (mismatch_count == 0 && pending_hits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
